// ===== hw/rtl/dics_pkg.sv =====
`default_nettype none

package dics_pkg;

    // payload widths of the channels
    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 8;
    localparam int WEIGHT_W  = 17;
    localparam int UNIFORM_W = 16;
    localparam int OUTCOME_W = 4;
    localparam int COUNT_W   = 5;

    // fixed point of the uniform fraction
    localparam int UNIFORM_SCALE_BITS = 16;

    localparam int DEF_MAX_OUTCOMES = 16;
    localparam int DEF_PROB_BITS    = 16;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_code_t;

    typedef struct packed {
        logic start;
        logic walk;
        logic cap_sample;
        logic cap_query;
        logic cap_empty;
        logic push;
    } dics_cmd_t;

    typedef struct packed {
        logic is_sample;
        logic is_query;
        logic n_zero;
        logic hit;
        logic last;
        logic out_free;
    } dics_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dics_ifs.sv =====
`default_nettype none

interface dics_in_if;
    logic                             valid;
    logic                             ready;
    logic [dics_pkg::CMD_W-1:0]       command;
    logic [dics_pkg::INDEX_W-1:0]     entry_index;
    logic [dics_pkg::WEIGHT_W-1:0]    weight;
    logic [dics_pkg::UNIFORM_W-1:0]   uniform_fraction;

    modport source (output valid, command, entry_index, weight, uniform_fraction,
                    input ready);
    modport sink (input valid, command, entry_index, weight, uniform_fraction,
                  output ready);
endinterface

interface dics_out_if;
    logic                             valid;
    logic                             ready;
    logic [dics_pkg::OUTCOME_W-1:0]   outcome;
    logic [dics_pkg::WEIGHT_W-1:0]    probability;
    logic                             fell_through;

    modport source (output valid, outcome, probability, fell_through, input ready);
    modport sink (input valid, outcome, probability, fell_through, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dics_ctrl.sv =====
`default_nettype none

module dics_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire dics_pkg::dics_stat_t stat,
    output dics_pkg::dics_cmd_t    cmd,
    output logic                   in_ready
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_QRY  = 4'b0100,
        S_PUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    if (stat.is_sample)
                    begin
                        if (stat.n_zero)
                        begin
                            cmd.cap_empty = 1'b1;
                            state_next    = S_PUSH;
                        end
                        else
                        begin
                            state_next = S_SUM;
                        end
                    end
                    else if (stat.is_query)
                    begin
                        state_next = S_QRY;
                    end
                end
            end
            S_SUM:
            begin
                // one table entry per cycle until the sum passes the fraction or the last entry is reached
                if (stat.hit || stat.last)
                begin
                    cmd.cap_sample = 1'b1;
                    state_next     = S_PUSH;
                end
                else
                begin
                    cmd.walk = 1'b1;
                end
            end
            S_QRY:
            begin
                cmd.cap_query = 1'b1;
                state_next    = S_PUSH;
            end
            S_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dics_datapath.sv =====
`default_nettype none

module dics_datapath #(
    parameter int MAX_OUTCOMES = dics_pkg::DEF_MAX_OUTCOMES,
    parameter int PROB_BITS    = dics_pkg::DEF_PROB_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [dics_pkg::CMD_W-1:0]        command,
    input  wire logic [dics_pkg::INDEX_W-1:0]      entry_index,
    input  wire logic [dics_pkg::WEIGHT_W-1:0]     weight,
    input  wire logic [dics_pkg::UNIFORM_W-1:0]    uniform_fraction,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dics_pkg::COUNT_W-1:0]      cfg_wr_data,
    input  wire dics_pkg::dics_cmd_t               cmd,
    output dics_pkg::dics_stat_t                   stat,
    dics_out_if.source                             out_ch
);

    localparam int IDX_W   = $clog2(MAX_OUTCOMES);
    localparam int SUM_W   = dics_pkg::WEIGHT_W + $clog2(MAX_OUTCOMES);
    localparam int LHS_W   = dics_pkg::UNIFORM_W + PROB_BITS;
    localparam int RHS_W   = SUM_W + dics_pkg::UNIFORM_SCALE_BITS;
    localparam int CMP_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam int WIDE_W  = dics_pkg::INDEX_W + 1;
    localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_OUTCOMES);
    localparam logic [dics_pkg::WEIGHT_W-1:0] RESET_ENTRY =
        dics_pkg::WEIGHT_W'((64'd1 << PROB_BITS) / MAX_OUTCOMES);

    logic [dics_pkg::WEIGHT_W-1:0] mem [MAX_OUTCOMES];
    logic [MAX_OUTCOMES-1:0]       valid_reg;

    logic [dics_pkg::COUNT_W-1:0]   count_reg;
    logic [dics_pkg::COUNT_W-1:0]   n_eff;
    logic [IDX_W-1:0]               i_reg;
    logic [SUM_W-1:0]               sum_reg;
    logic [SUM_W-1:0]               sum_next;
    logic [dics_pkg::UNIFORM_W-1:0] u_reg;
    logic [dics_pkg::INDEX_W-1:0]   idx_reg;
    logic [dics_pkg::WEIGHT_W-1:0]  rd_data_reg;
    logic [IDX_W-1:0]               rd_addr;
    logic                           wr_en;
    logic [CMP_W-1:0]               lhs;
    logic [CMP_W-1:0]               rhs;
    logic                           query_in_range;

    logic [dics_pkg::OUTCOME_W-1:0] res_outcome_reg;
    logic [dics_pkg::WEIGHT_W-1:0]  res_prob_reg;
    logic                           res_fall_reg;

    logic                           out_valid_reg;
    logic [dics_pkg::OUTCOME_W-1:0] out_outcome_reg;
    logic [dics_pkg::WEIGHT_W-1:0]  out_prob_reg;
    logic                           out_fall_reg;

    // a count above the table acts as the table size
    assign n_eff = (WIDE_W'(count_reg) > MAX_WIDE) ? dics_pkg::COUNT_W'(MAX_OUTCOMES)
                                                   : count_reg;

    assign wr_en = cmd.start && (command == dics_pkg::CMD_WRITE)
                   && (WIDE_W'(entry_index) < MAX_WIDE);

    always_comb
    begin
        if (cmd.start)
        begin
            rd_addr = (command == dics_pkg::CMD_SAMPLE) ? '0 : entry_index[IDX_W-1:0];
        end
        else
        begin
            rd_addr = i_reg + IDX_W'(1);
        end
    end

    // exact compare of u / 2^16 against sum / 2^PROB_BITS
    assign sum_next = sum_reg + SUM_W'(rd_data_reg);
    assign lhs      = CMP_W'(u_reg) << PROB_BITS;
    assign rhs      = CMP_W'(sum_next) << dics_pkg::UNIFORM_SCALE_BITS;

    assign query_in_range = WIDE_W'(idx_reg) < WIDE_W'(n_eff);

    assign stat.is_sample = (command == dics_pkg::CMD_SAMPLE);
    assign stat.is_query  = (command == dics_pkg::CMD_QUERY);
    assign stat.n_zero    = (n_eff == '0);
    assign stat.hit       = (lhs < rhs);
    assign stat.last      = (WIDE_W'(i_reg) + WIDE_W'(1)) == WIDE_W'(n_eff);
    assign stat.out_free  = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[entry_index[IDX_W-1:0]] <= weight;
        end
    end

    // entries never written read as the reset share
    always_ff @(posedge clk)
    begin
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : RESET_ENTRY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= dics_pkg::COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[entry_index[IDX_W-1:0]] <= 1'b1;
            end
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            i_reg   <= '0;
            sum_reg <= '0;
            u_reg   <= uniform_fraction;
            idx_reg <= entry_index;
        end
        else if (cmd.walk)
        begin
            i_reg   <= i_reg + IDX_W'(1);
            sum_reg <= sum_next;
        end

        if (cmd.cap_sample)
        begin
            res_outcome_reg <= stat.hit ? dics_pkg::OUTCOME_W'(i_reg) : '0;
            res_prob_reg    <= '0;
            res_fall_reg    <= !stat.hit;
        end
        else if (cmd.cap_query)
        begin
            res_outcome_reg <= '0;
            res_prob_reg    <= query_in_range ? rd_data_reg : '0;
            res_fall_reg    <= 1'b0;
        end
        else if (cmd.cap_empty)
        begin
            res_outcome_reg <= '0;
            res_prob_reg    <= '0;
            res_fall_reg    <= 1'b1;
        end

        if (cmd.push)
        begin
            out_outcome_reg <= res_outcome_reg;
            out_prob_reg    <= res_prob_reg;
            out_fall_reg    <= res_fall_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.outcome      = out_outcome_reg;
    assign out_ch.probability  = out_prob_reg;
    assign out_ch.fell_through = out_fall_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/discrete_inverse_cdf_sampler_unit.sv =====
// Inverse-CDF sampler over a table of up to MAX_OUTCOMES probabilities.
// Input channel (in): one transaction carries command, entry_index, weight
// and uniform_fraction. A write stores weight and returns nothing; a sample
// returns the first outcome whose running sum exceeds the fraction (or 0
// with fell_through); a query returns the stored probability, 0 when out of
// range. Output channel (out) carries outcome, probability, fell_through.
// cfg_wr_en / cfg_wr_data set outcome_count; write it only while idle.
// A write is done on acceptance; a query reads its entry, then
// captures and stages its result. A sample walks the table one entry
// per cycle through the single read port of the table, stopping at the
// first hit or at index outcome_count - 1; with a count of zero it skips
// the walk. The next transaction is taken in the cycle after staging.
// Reset: every entry reads as 2^PROB_BITS / MAX_OUTCOMES, count is 16,
// no result pending. When the receiver stalls, the result waits in the
// output register; the block still takes writes and one more sample or
// query, works it, then holds that result until the output register frees.
`default_nettype none

module discrete_inverse_cdf_sampler_unit #(
    parameter int MAX_OUTCOMES = dics_pkg::DEF_MAX_OUTCOMES,
    parameter int PROB_BITS    = dics_pkg::DEF_PROB_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    dics_in_if.sink                            in,
    dics_out_if.source                         out,
    input  wire logic                          cfg_wr_en,
    input  wire logic [dics_pkg::COUNT_W-1:0]  cfg_wr_data
);

    dics_pkg::dics_cmd_t  cmd;
    dics_pkg::dics_stat_t stat;
    logic                 in_ready;

    dics_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in.valid),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    dics_datapath #(
        .MAX_OUTCOMES (MAX_OUTCOMES),
        .PROB_BITS    (PROB_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .command          (in.command),
        .entry_index      (in.entry_index),
        .weight           (in.weight),
        .uniform_fraction (in.uniform_fraction),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .cmd              (cmd),
        .stat             (stat),
        .out_ch           (out)
    );

    assign in.ready = in_ready;

    // a sample occupies the walk, so no transaction is taken right after it
    a_sample_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in.valid && in.ready && in.command == dics_pkg::CMD_SAMPLE) |=> !in.ready)
        else $error("input taken while a sample is being walked");

    // results only appear through a push from the controller
    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (!out.valid && !cmd.push) |=> !out.valid)
        else $error("result appeared without a push");

    // a write command never produces a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in.valid && in.ready && in.command == dics_pkg::CMD_WRITE && !out.valid)
        |=> !out.valid)
        else $error("write transaction produced a result");

endmodule

`default_nettype wire
